>>> sv/tdat_pkg.sv
package tdat_pkg;

  // table size at which the block is normally built
  localparam int DEF_SLOTS = 16;

  // most moves one tick reports
  localparam int MOVE_MAX = 16;

  // request codes
  typedef enum logic [2:0] {
    REQ_ADD        = 3'd0,
    REQ_UPDATE     = 3'd1,
    REQ_DELETE     = 3'd2,
    REQ_GET        = 3'd3,
    REQ_SET_ACTIVE = 3'd4,
    REQ_TICK       = 3'd5
  } req_t;

  // stored entry commands
  localparam logic [1:0] CMD_OPEN    = 2'd1;
  localparam logic [1:0] CMD_SUNSET  = 2'd2;
  localparam logic [1:0] CMD_SUNRISE = 2'd3;

  // kind of result the datapath puts on the result ports
  typedef enum logic [2:0] {
    EM_NONE,
    EM_EDIT,
    EM_ADD,
    EM_GET,
    EM_FLUSH
  } emit_t;

  // controller to datapath commands
  typedef struct packed {
    logic  load;
    logic  idx_inc;
    logic  add_commit;
    logic  edit_commit;
    logic  tick_issue;
    logic  tick_eval;
    emit_t emit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic idx_last;
    logic hit;
    logic hit_full;
  } dp_stat_t;

endpackage

>>> sv/time_of_day_action_table.sv
// Schedule table of up to SLOTS shutter actions. A request is taken when start is high
// and busy is low; its results come out on the result ports, each for a single cycle
// marked by result_strobe, and the last one carries last. The receiver cannot hold
// results off. Update, delete, set_active and unknown requests go from acceptance
// through the edit state to the result register, get adds one registered table read,
// add walks the used flags one slot per cycle to find the lowest free slot, and a tick
// reads the table one slot per cycle through its single read port and judges each
// entry in the cycle after its read; a tick that reaches 16 moves ends early. busy
// drops with the last result, so the next request may be accepted while that result
// is on the ports.
module time_of_day_action_table #(
  parameter int SLOTS = tdat_pkg::DEF_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type,
  input  logic [3:0] slot,
  input  logic [7:0] roller,
  input  logic [4:0] hour,
  input  logic [5:0] minute,
  input  logic [1:0] command,
  input  logic       active,
  input  logic [4:0] sunrise_hour,
  input  logic [5:0] sunrise_minute,
  input  logic [4:0] sunset_hour,
  input  logic [5:0] sunset_minute,
  input  logic       sun_valid,
  output logic       result_strobe,
  output logic       ok,
  output logic [3:0] slot_out,
  output logic [7:0] roller_out,
  output logic [4:0] hour_out,
  output logic [5:0] minute_out,
  output logic [1:0] command_out,
  output logic       active_out,
  output logic [4:0] used_count,
  output logic       move_valid,
  output logic       move_up,
  output logic       last
);
  import tdat_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  tdat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // table, scan and result registers
  tdat_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .slot           (slot),
    .roller         (roller),
    .hour           (hour),
    .minute         (minute),
    .command        (command),
    .active         (active),
    .sunrise_hour   (sunrise_hour),
    .sunrise_minute (sunrise_minute),
    .sunset_hour    (sunset_hour),
    .sunset_minute  (sunset_minute),
    .sun_valid      (sun_valid),
    .result_strobe  (result_strobe),
    .ok             (ok),
    .slot_out       (slot_out),
    .roller_out     (roller_out),
    .hour_out       (hour_out),
    .minute_out     (minute_out),
    .command_out    (command_out),
    .active_out     (active_out),
    .used_count     (used_count),
    .move_valid     (move_valid),
    .move_up        (move_up),
    .last           (last)
  );

  // an accepted request always keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a result only follows a cycle in which a request was in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result transfer without a request in progress");

  // a result that is not the last one leaves the request still in progress
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |-> busy)
    else $error("non-final result after the request ended");

  // moves come only from ticks and always succeed
  a_move_ok: assert property (@(posedge clk) disable iff (rst)
    result_strobe && move_valid |-> ok && (used_count != 5'd0))
    else $error("move reported without success or without used slots");

endmodule

>>> sv/tdat_ctrl.sv
module tdat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         req_type,
  input  tdat_pkg::dp_stat_t stat,
  output tdat_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import tdat_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_GET,
    S_GET_OUT,
    S_ADD,
    S_TICK,
    S_TICK_END,
    S_FLUSH
  } state_t;

  state_t state, state_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit = EM_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (req_type)
            REQ_ADD:  state_next = S_ADD;
            REQ_GET:  state_next = S_GET;
            REQ_TICK: state_next = S_TICK;
            default:  state_next = S_EDIT;
          endcase
        end
      end
      S_EDIT: begin
        cmd.edit_commit = 1'b1;
        cmd.emit = EM_EDIT;
        state_next = S_IDLE;
      end
      S_GET: begin
        state_next = S_GET_OUT;
      end
      S_GET_OUT: begin
        cmd.emit = EM_GET;
        state_next = S_IDLE;
      end
      S_ADD: begin
        if (stat.slot_free) begin
          cmd.add_commit = 1'b1;
          cmd.emit = EM_ADD;
          state_next = S_IDLE;
        end else if (stat.idx_last) begin
          cmd.emit = EM_ADD;
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TICK: begin
        cmd.tick_issue = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.tick_eval = 1'b1;
        if (stat.hit_full) begin
          state_next = S_FLUSH;
        end else if (stat.idx_last) begin
          state_next = S_TICK_END;
        end
      end
      S_TICK_END: begin
        cmd.tick_eval = 1'b1;
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.emit = EM_FLUSH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      state <= state_next;
      busy <= (state_next != S_IDLE);
    end
  end

endmodule

>>> sv/tdat_dp.sv
module tdat_dp #(
  parameter int SLOTS = tdat_pkg::DEF_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  tdat_pkg::ctl_cmd_t cmd,
  output tdat_pkg::dp_stat_t stat,
  input  logic [2:0]         req_type,
  input  logic [3:0]         slot,
  input  logic [7:0]         roller,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [1:0]         command,
  input  logic               active,
  input  logic [4:0]         sunrise_hour,
  input  logic [5:0]         sunrise_minute,
  input  logic [4:0]         sunset_hour,
  input  logic [5:0]         sunset_minute,
  input  logic               sun_valid,
  output logic               result_strobe,
  output logic               ok,
  output logic [3:0]         slot_out,
  output logic [7:0]         roller_out,
  output logic [4:0]         hour_out,
  output logic [5:0]         minute_out,
  output logic [1:0]         command_out,
  output logic               active_out,
  output logic [4:0]         used_count,
  output logic               move_valid,
  output logic               move_up,
  output logic               last
);
  import tdat_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(SLOTS - 1);
  localparam logic [4:0] MOVES_FULL = 5'(MOVE_MAX - 1);

  typedef struct packed {
    logic [7:0] roller;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] command;
  } entry_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] slot;
    logic [7:0] roller;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] command;
    logic       active;
    logic       move_valid;
    logic       move_up;
    logic       last;
  } res_t;

  // latched request
  logic [2:0] r_type;
  logic [3:0] r_slot;
  logic [7:0] r_roller;
  logic [4:0] r_hour;
  logic [5:0] r_minute;
  logic [1:0] r_cmd;
  logic       r_act;
  logic [4:0] r_rise_h;
  logic [5:0] r_rise_m;
  logic [4:0] r_set_h;
  logic [5:0] r_set_m;
  logic       r_sun;

  // table storage
  entry_t           ent_mem [SLOTS];
  logic             en_mem  [SLOTS];
  entry_t           ent_q;
  logic             en_q;
  logic [SLOTS-1:0] used;
  logic [CW-1:0]    count, count_next;

  logic [AW-1:0] idx, slot_addr, rd_addr;
  logic          in_range, slot_used_s, slot_free;
  logic          upd_we, del_we, act_we, edit_ok;

  // tick scan stage
  logic          stage_v, stage_used;
  logic [AW-1:0] stage_idx;
  logic [4:0]    eff_h;
  logic [5:0]    eff_m;
  logic          eff_up, hit;
  logic [4:0]    moves;
  logic          pend_valid, pend_up;
  logic [3:0]    pend_slot;
  logic [7:0]    pend_roller;

  res_t res_next;
  logic res_fire;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_type   <= req_type;
      r_slot   <= slot;
      r_roller <= roller;
      r_hour   <= hour;
      r_minute <= minute;
      r_cmd    <= command;
      r_act    <= active;
      r_rise_h <= sunrise_hour;
      r_rise_m <= sunrise_minute;
      r_set_h  <= sunset_hour;
      r_set_m  <= sunset_minute;
      r_sun    <= sun_valid;
    end
  end

  // slot checks
  assign in_range    = {28'b0, r_slot} < 32'(SLOTS);
  assign slot_addr   = AW'(r_slot);
  assign slot_used_s = in_range && used[slot_addr];
  assign slot_free   = !used[idx];

  // edit decode
  assign upd_we = cmd.edit_commit && (r_type == REQ_UPDATE) && slot_used_s;
  assign del_we = cmd.edit_commit && (r_type == REQ_DELETE) && in_range;
  assign act_we = cmd.edit_commit && (r_type == REQ_SET_ACTIVE) && slot_used_s;

  always_comb begin
    unique case (r_type)
      REQ_UPDATE:     edit_ok = slot_used_s;
      REQ_DELETE:     edit_ok = in_range;
      REQ_SET_ACTIVE: edit_ok = slot_used_s;
      default:        edit_ok = 1'b0;
    endcase
  end

  // entry contents memory
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      ent_mem[idx] <= '{roller: r_roller, hour: r_hour, minute: r_minute, command: r_cmd};
    end else if (upd_we) begin
      ent_mem[slot_addr] <= '{roller: r_roller, hour: r_hour, minute: r_minute,
                              command: r_cmd};
    end
  end

  // enable flag memory
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      en_mem[idx] <= 1'b1;
    end else if (act_we) begin
      en_mem[slot_addr] <= r_act;
    end
  end

  // registered read, scan index while ticking, named slot otherwise
  assign rd_addr = cmd.tick_issue ? idx : slot_addr;

  always_ff @(posedge clk) begin
    ent_q <= ent_mem[rd_addr];
    en_q  <= en_mem[rd_addr];
  end

  // used flags and count
  always_comb begin
    count_next = count;
    if (cmd.add_commit) begin
      count_next = count + CW'(1);
    end else if (del_we && used[slot_addr]) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      count <= '0;
    end else begin
      if (cmd.add_commit) begin
        used[idx] <= 1'b1;
      end
      if (del_we) begin
        used[slot_addr] <= 1'b0;
      end
      count <= count_next;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  // read stage alongside the table data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else begin
      stage_v <= cmd.tick_issue;
    end
    stage_idx  <= idx;
    stage_used <= used[idx];
  end

  // effective time and direction of the entry in the read stage
  always_comb begin
    eff_h  = ent_q.hour;
    eff_m  = ent_q.minute;
    eff_up = (ent_q.command == CMD_OPEN);
    if (ent_q.command == CMD_SUNSET) begin
      if (r_sun) begin
        eff_h = r_set_h;
        eff_m = r_set_m;
      end
      eff_up = 1'b0;
    end else if (ent_q.command == CMD_SUNRISE) begin
      if (r_sun) begin
        eff_h = r_rise_h;
        eff_m = r_rise_m;
      end
      eff_up = 1'b1;
    end
  end

  assign hit = stage_v && stage_used && en_q && (eff_h == r_hour) && (eff_m == r_minute);

  // status to the controller
  assign stat.slot_free = slot_free;
  assign stat.idx_last  = (idx == IDX_LAST);
  assign stat.hit       = hit;
  assign stat.hit_full  = hit && (moves == MOVES_FULL);

  // move count and the pending move, held until it is known whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      moves <= '0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
      moves <= '0;
    end else if (cmd.tick_eval && hit) begin
      pend_valid <= 1'b1;
      moves <= moves + 5'd1;
    end
    if (cmd.tick_eval && hit) begin
      pend_slot   <= 4'(stage_idx);
      pend_roller <= ent_q.roller;
      pend_up     <= eff_up;
    end
  end

  // result select
  always_comb begin
    res_next = '0;
    res_fire = 1'b0;
    if (cmd.tick_eval && hit && pend_valid) begin
      res_fire            = 1'b1;
      res_next.ok         = 1'b1;
      res_next.slot       = pend_slot;
      res_next.roller     = pend_roller;
      res_next.move_valid = 1'b1;
      res_next.move_up    = pend_up;
    end
    unique case (cmd.emit)
      EM_EDIT: begin
        res_fire      = 1'b1;
        res_next.ok   = edit_ok;
        res_next.last = 1'b1;
      end
      EM_ADD: begin
        res_fire      = 1'b1;
        res_next.ok   = slot_free;
        res_next.slot = slot_free ? 4'(idx) : 4'd0;
        res_next.last = 1'b1;
      end
      EM_GET: begin
        res_fire      = 1'b1;
        res_next.last = 1'b1;
        if (slot_used_s) begin
          res_next.ok      = 1'b1;
          res_next.slot    = r_slot;
          res_next.roller  = ent_q.roller;
          res_next.hour    = ent_q.hour;
          res_next.minute  = ent_q.minute;
          res_next.command = ent_q.command;
          res_next.active  = en_q;
        end
      end
      EM_FLUSH: begin
        res_fire      = 1'b1;
        res_next.ok   = 1'b1;
        res_next.last = 1'b1;
        if (pend_valid) begin
          res_next.slot       = pend_slot;
          res_next.roller     = pend_roller;
          res_next.move_valid = 1'b1;
          res_next.move_up    = pend_up;
        end
      end
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= res_fire;
    end
    ok          <= res_next.ok;
    slot_out    <= res_next.slot;
    roller_out  <= res_next.roller;
    hour_out    <= res_next.hour;
    minute_out  <= res_next.minute;
    command_out <= res_next.command;
    active_out  <= res_next.active;
    move_valid  <= res_next.move_valid;
    move_up     <= res_next.move_up;
    last        <= res_next.last;
    used_count  <= (32'(count_next) > 32'd31) ? 5'd31 : 5'(count_next);
  end

endmodule

>>> dv/time_of_day_action_table_tb.sv
module time_of_day_action_table_tb;
  import tdat_pkg::*;

  localparam int TBL_SLOTS = DEF_SLOTS;
  localparam logic [2:0] REQ_BAD_LO = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;
  localparam logic [1:0] CMD_CLOSE = 2'd0;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * (TBL_SLOTS + 3);
  localparam int RAND_ITEMS = 135;
  localparam int NO_GAP_ITEMS = 60;

  // one request as driven on the ports
  typedef struct packed {
    logic [2:0] req;
    logic [3:0] slot;
    logic [7:0] roller;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] cmd;
    logic       active;
    logic [4:0] rise_h;
    logic [5:0] rise_m;
    logic [4:0] set_h;
    logic [5:0] set_m;
    logic       sun_valid;
  } req_item_t;

  // one result as seen on the result ports
  typedef struct packed {
    logic       ok;
    logic [3:0] slot;
    logic [7:0] roller;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [1:0] cmd;
    logic       active;
    logic [4:0] count;
    logic       mv;
    logic       up;
    logic       last;
  } tbl_res_t;

  // directed row: request plus an optional hand-written result
  typedef struct packed {
    req_item_t it;
    logic      typed;
    tbl_res_t  res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] req_type;
  logic [3:0] slot;
  logic [7:0] roller;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [1:0] command;
  logic       active;
  logic [4:0] sunrise_hour;
  logic [5:0] sunrise_minute;
  logic [4:0] sunset_hour;
  logic [5:0] sunset_minute;
  logic       sun_valid;
  logic       result_strobe;
  logic       ok;
  logic [3:0] slot_out;
  logic [7:0] roller_out;
  logic [4:0] hour_out;
  logic [5:0] minute_out;
  logic [1:0] command_out;
  logic       active_out;
  logic [4:0] used_count;
  logic       move_valid;
  logic       move_up;
  logic       last;

  req_item_t cur_item = '0;
  logic      cur_typed = 1'b0;
  tbl_res_t  cur_fixed = '0;

  // shadow copy of the schedule table
  logic       e_used    [TBL_SLOTS] = '{default: 1'b0};
  logic       e_enabled [TBL_SLOTS] = '{default: 1'b0};
  logic [7:0] e_roller  [TBL_SLOTS] = '{default: 8'd0};
  logic [4:0] e_hour    [TBL_SLOTS] = '{default: 5'd0};
  logic [5:0] e_minute  [TBL_SLOTS] = '{default: 6'd0};
  logic [1:0] e_cmd     [TBL_SLOTS] = '{default: 2'd0};

  tbl_res_t pred_q[$];
  tbl_res_t pending_res[$];
  dir_row_t dir_rows[$];

  int err_cnt = 0;
  int stall_cnt = 0;
  int n_req = 0;
  int n_tick = 0;
  int n_res = 0;
  int n_move = 0;
  int n_full = 0;

  // request fields onto the ports
  assign req_type       = cur_item.req;
  assign slot           = cur_item.slot;
  assign roller         = cur_item.roller;
  assign hour           = cur_item.hour;
  assign minute         = cur_item.minute;
  assign command        = cur_item.cmd;
  assign active         = cur_item.active;
  assign sunrise_hour   = cur_item.rise_h;
  assign sunrise_minute = cur_item.rise_m;
  assign sunset_hour    = cur_item.set_h;
  assign sunset_minute  = cur_item.set_m;
  assign sun_valid      = cur_item.sun_valid;

  time_of_day_action_table DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [4:0] used_total();
    int i;
    int n;
    n = 0;
    for (i = 0; i < TBL_SLOTS; i++) begin
      if (e_used[i]) n++;
    end
    return (n > 31) ? 5'd31 : 5'(n);
  endfunction

  // schedule table behavior: updates the shadow table, leaves results in pred_q
  task automatic table_apply(input req_item_t it);
    tbl_res_t   r;
    int         i;
    int         n;
    int         free_idx;
    logic [4:0] h;
    logic [4:0] cnt;
    logic [5:0] m;
    logic [1:0] c;
    pred_q.delete();
    r = '0;
    n = 0;
    free_idx = -1;
    case (it.req)
      REQ_TICK: begin
        cnt = used_total();
        for (i = 0; i < TBL_SLOTS && n < MOVE_MAX; i++) begin
          if (e_used[i]) begin
            h = e_hour[i];
            m = e_minute[i];
            c = e_cmd[i];
            // sun-relative entries take today's sun time when it is known
            if (c == CMD_SUNSET) begin
              if (it.sun_valid) begin
                h = it.set_h;
                m = it.set_m;
              end
              c = CMD_CLOSE;
            end else if (c == CMD_SUNRISE) begin
              if (it.sun_valid) begin
                h = it.rise_h;
                m = it.rise_m;
              end
              c = CMD_OPEN;
            end
            if (e_enabled[i] && h == it.hour && m == it.minute) begin
              r = '0;
              r.ok = 1'b1;
              r.slot = 4'(i);
              r.roller = e_roller[i];
              r.mv = 1'b1;
              r.up = (c == CMD_OPEN);
              r.count = cnt;
              pred_q.push_back(r);
              n++;
            end
          end
        end
        // nothing fired: one plain acknowledge
        if (n == 0) begin
          r = '0;
          r.ok = 1'b1;
          r.count = cnt;
          pred_q.push_back(r);
        end
        r = pred_q.pop_back();
        r.last = 1'b1;
        pred_q.push_back(r);
      end
      default: begin
        case (it.req)
          REQ_ADD: begin
            for (i = TBL_SLOTS - 1; i >= 0; i--) begin
              if (!e_used[i]) free_idx = i;
            end
            if (free_idx >= 0) begin
              e_used[free_idx] = 1'b1;
              e_enabled[free_idx] = 1'b1;
              e_roller[free_idx] = it.roller;
              e_hour[free_idx] = it.hour;
              e_minute[free_idx] = it.minute;
              e_cmd[free_idx] = it.cmd;
              r.ok = 1'b1;
              r.slot = 4'(free_idx);
            end else begin
              n_full++;
            end
          end
          REQ_UPDATE: begin
            if (e_used[it.slot]) begin
              e_roller[it.slot] = it.roller;
              e_hour[it.slot] = it.hour;
              e_minute[it.slot] = it.minute;
              e_cmd[it.slot] = it.cmd;
              r.ok = 1'b1;
            end
          end
          REQ_DELETE: begin
            e_used[it.slot] = 1'b0;
            r.ok = 1'b1;
          end
          REQ_GET: begin
            if (e_used[it.slot]) begin
              r.ok = 1'b1;
              r.slot = it.slot;
              r.roller = e_roller[it.slot];
              r.hour = e_hour[it.slot];
              r.minute = e_minute[it.slot];
              r.cmd = e_cmd[it.slot];
              r.active = e_enabled[it.slot];
            end
          end
          REQ_SET_ACTIVE: begin
            if (e_used[it.slot]) begin
              e_enabled[it.slot] = it.active;
              r.ok = 1'b1;
            end
          end
          default: begin
            r.ok = 1'b0;
          end
        endcase
        r.count = used_total();
        r.last = 1'b1;
        pred_q.push_back(r);
      end
    endcase
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  function automatic req_item_t edit_item(logic [2:0] req, logic [3:0] s, logic [7:0] rl,
                                          logic [4:0] h, logic [5:0] m, logic [1:0] c,
                                          logic a);
    req_item_t it;
    it = '0;
    it.req = req;
    it.slot = s;
    it.roller = rl;
    it.hour = h;
    it.minute = m;
    it.cmd = c;
    it.active = a;
    return it;
  endfunction

  function automatic req_item_t tick_item(logic [4:0] h, logic [5:0] m, logic [4:0] rh,
                                          logic [5:0] rm, logic [4:0] sh, logic [5:0] sm,
                                          logic sv);
    req_item_t it;
    it = '0;
    it.req = REQ_TICK;
    it.hour = h;
    it.minute = m;
    it.rise_h = rh;
    it.rise_m = rm;
    it.set_h = sh;
    it.set_m = sm;
    it.sun_valid = sv;
    return it;
  endfunction

  function automatic tbl_res_t res_of(logic o, logic [3:0] s, logic [7:0] rl, logic [4:0] h,
                                      logic [5:0] m, logic [1:0] c, logic a,
                                      logic [4:0] cnt);
    tbl_res_t r;
    r = '0;
    r.ok = o;
    r.slot = s;
    r.roller = rl;
    r.hour = h;
    r.minute = m;
    r.cmd = c;
    r.active = a;
    r.count = cnt;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic add_row(input req_item_t it, input logic typed, input tbl_res_t res);
    dir_row_t row;
    row.it = it;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // mostly a small pool of times so that ticks hit, sometimes any encodable time
  function automatic void pick_time(output logic [4:0] h, output logic [5:0] m);
    if ($urandom_range(0, 99) < 80) begin
      h = ($urandom_range(0, 1) != 0) ? 5'd19 : 5'd7;
      m = ($urandom_range(0, 1) != 0) ? 6'd30 : 6'd0;
    end else begin
      h = 5'($urandom_range(0, 31));
      m = 6'($urandom_range(0, 63));
    end
  endfunction

  function automatic req_item_t rand_item();
    req_item_t   it;
    logic [63:0] raw;
    int          pick;
    int          k;
    // unused fields carry random bits too
    raw = {$urandom, $urandom};
    it = raw[$bits(req_item_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 24) it.req = REQ_ADD;
    else if (pick < 34) it.req = REQ_UPDATE;
    else if (pick < 46) it.req = REQ_DELETE;
    else if (pick < 58) it.req = REQ_GET;
    else if (pick < 68) it.req = REQ_SET_ACTIVE;
    else if (pick < 94) it.req = REQ_TICK;
    else it.req = ($urandom_range(0, 1) != 0) ? REQ_BAD_HI : REQ_BAD_LO;
    pick_time(it.hour, it.minute);
    if (it.req == REQ_TICK) begin
      pick_time(it.rise_h, it.rise_m);
      pick_time(it.set_h, it.set_m);
      // often aim the tick at a stored entry
      k = $urandom_range(0, TBL_SLOTS - 1);
      if (e_used[k] && $urandom_range(0, 1) != 0) begin
        it.hour = e_hour[k];
        it.minute = e_minute[k];
      end
    end
    return it;
  endfunction

  // one request transfer, with an optional idle gap in front
  task automatic send_item(input req_item_t it, input logic typed, input tbl_res_t fixed,
                           input logic may_idle);
    if (may_idle && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    cur_item <= it;
    cur_typed <= typed;
    cur_fixed <= fixed;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // result check, then prediction for an accepted request
  always @(posedge clk) begin
    tbl_res_t want;
    if (!rst) begin
      if (result_strobe) begin
        n_res++;
        if (move_valid) n_move++;
        if (pending_res.size() == 0) begin
          $error("result with nothing pending: slot_out %0d, last %0d", slot_out, last);
          err_cnt++;
        end else begin
          want = pending_res.pop_front();
          check_field("ok", 8'(want.ok), 8'(ok));
          check_field("slot_out", 8'(want.slot), 8'(slot_out));
          check_field("roller_out", want.roller, roller_out);
          check_field("hour_out", 8'(want.hour), 8'(hour_out));
          check_field("minute_out", 8'(want.minute), 8'(minute_out));
          check_field("command_out", 8'(want.cmd), 8'(command_out));
          check_field("active_out", 8'(want.active), 8'(active_out));
          check_field("used_count", 8'(want.count), 8'(used_count));
          check_field("move_valid", 8'(want.mv), 8'(move_valid));
          check_field("move_up", 8'(want.up), 8'(move_up));
          check_field("last", 8'(want.last), 8'(last));
        end
      end
      if (start && !busy) begin
        n_req++;
        if (cur_item.req == REQ_TICK) n_tick++;
        table_apply(cur_item);
        if (cur_typed) begin
          pending_res.push_back(cur_fixed);
        end else begin
          foreach (pred_q[j]) pending_res.push_back(pred_q[j]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $error("watchdog: no transfer for %0d cycles, %0d results pending", stall_cnt,
           pending_res.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int i;
    // directed rows: empty table first, then extremes, sun handling and edits
    add_row(edit_item(REQ_GET, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b1,
            res_of(1'b0, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(tick_item(5'd0, 6'd0, 5'd0, 6'd0, 5'd0, 6'd0, 1'b0), 1'b1,
            res_of(1'b1, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(edit_item(REQ_DELETE, 4'd15, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b1,
            res_of(1'b1, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(edit_item(REQ_UPDATE, 4'd3, 8'd17, 5'd1, 6'd2, CMD_OPEN, 1'b0), 1'b1,
            res_of(1'b0, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(edit_item(REQ_SET_ACTIVE, 4'd5, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b1), 1'b1,
            res_of(1'b0, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(edit_item(REQ_BAD_LO, 4'hF, 8'hFF, 5'h1F, 6'h3F, CMD_SUNRISE, 1'b1), 1'b1,
            res_of(1'b0, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(edit_item(REQ_BAD_HI, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b1,
            res_of(1'b0, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd0));
    add_row(edit_item(REQ_ADD, 4'd9, 8'hFF, 5'd23, 6'd59, CMD_CLOSE, 1'b0), 1'b1,
            res_of(1'b1, 4'd0, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd1));
    add_row(edit_item(REQ_ADD, 4'd0, 8'h00, 5'd0, 6'd0, CMD_OPEN, 1'b1), 1'b1,
            res_of(1'b1, 4'd1, 8'd0, 5'd0, 6'd0, 2'd0, 1'b0, 5'd2));
    // stored time that no clock shows
    add_row(edit_item(REQ_ADD, 4'd0, 8'hA5, 5'd31, 6'd63, CMD_SUNSET, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_ADD, 4'd0, 8'h5A, 5'd12, 6'd30, CMD_SUNRISE, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_GET, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b1,
            res_of(1'b1, 4'd0, 8'hFF, 5'd23, 6'd59, CMD_CLOSE, 1'b1, 5'd4));
    add_row(tick_item(5'd23, 6'd59, 5'd0, 6'd0, 5'd0, 6'd0, 1'b0), 1'b0, '0);
    add_row(tick_item(5'd0, 6'd0, 5'd31, 6'd63, 5'd31, 6'd63, 1'b0), 1'b0, '0);
    // sun entries fall back to their stored time, then follow the sun times
    add_row(tick_item(5'd12, 6'd30, 5'd6, 6'd15, 5'd20, 6'd45, 1'b0), 1'b0, '0);
    add_row(tick_item(5'd6, 6'd15, 5'd6, 6'd15, 5'd20, 6'd45, 1'b1), 1'b0, '0);
    add_row(tick_item(5'd20, 6'd45, 5'd6, 6'd15, 5'd20, 6'd45, 1'b1), 1'b0, '0);
    add_row(tick_item(5'd31, 6'd63, 5'd6, 6'd15, 5'd20, 6'd45, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_SET_ACTIVE, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b0, '0);
    add_row(tick_item(5'd23, 6'd59, 5'd0, 6'd0, 5'd0, 6'd0, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_GET, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_UPDATE, 4'd1, 8'h3C, 5'd23, 6'd59, CMD_SUNRISE, 1'b0), 1'b0, '0);
    // deleted slot reads back as unused and is reused by the next add
    add_row(edit_item(REQ_DELETE, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_GET, 4'd0, 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0), 1'b0, '0);
    add_row(edit_item(REQ_ADD, 4'd0, 8'h81, 5'd7, 6'd0, CMD_OPEN, 1'b0), 1'b0, '0);

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res, 1'b1);

    // random mix with gaps
    for (i = 0; i < RAND_ITEMS; i++) send_item(rand_item(), 1'b0, '0, 1'b1);

    // empty the table, overfill it with one time, then a tick that fires every slot
    for (i = 0; i < TBL_SLOTS; i++) begin
      send_item(edit_item(REQ_DELETE, 4'(i), 8'd0, 5'd0, 6'd0, CMD_CLOSE, 1'b0),
                1'b0, '0, 1'b0);
    end
    for (i = 0; i <= TBL_SLOTS; i++) begin
      send_item(edit_item(REQ_ADD, 4'($urandom), 8'($urandom), 5'd9, 6'd15,
                          2'($urandom_range(0, 3)), 1'b0), 1'b0, '0, 1'b0);
    end
    send_item(tick_item(5'd9, 6'd15, 5'($urandom), 6'($urandom), 5'($urandom),
                        6'($urandom), 1'b0), 1'b0, '0, 1'b0);
    send_item(tick_item(5'd9, 6'd15, 5'd9, 6'd15, 5'd9, 6'd15, 1'b1), 1'b0, '0, 1'b0);

    // random again, the first stretch back to back
    for (i = 0; i < RAND_ITEMS; i++) send_item(rand_item(), 1'b0, '0, i >= NO_GAP_ITEMS);
    start <= 1'b0;

    // drain, then a quiet tail to catch stray results
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d of them ticks, with %0d adds to a full table",
             n_req, n_tick, n_full);
    $display("checked %0d results, %0d of them shutter moves", n_res, n_move);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
